FILE: design/lccp_pkg.sv
// Package for the lattice coefficient compressor and packer.
// Holds the request and result types, the rounding constants and the register map.
// No dependencies.
package lccp_pkg;

   localparam int NUM_LANES = 8;
   localparam int COEFF_WIDTH = 16;
   localparam int QUOT_WIDTH = 11;
   localparam int OPERAND_WIDTH = 28;
   localparam int RECIP_WIDTH = 29;
   localparam int PRODUCT_WIDTH = OPERAND_WIDTH + RECIP_WIDTH;
   localparam int RECIP_SHIFT = 40;
   localparam int WIDE_PACK_BITS = NUM_LANES * 11;
   localparam int NARROW_PACK_BITS = NUM_LANES * 10;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [COEFF_WIDTH-1:0] MODULUS = 16'd3329;
   localparam logic [OPERAND_WIDTH-1:0] HALF_MODULUS = 28'd1664;
   localparam logic [RECIP_WIDTH-1:0] RECIP = 29'd330282857;

   localparam logic [3:0] WIDE_BITS = 4'd11;
   localparam logic [3:0] NARROW_BITS = 4'd10;
   localparam logic [3:0] COEFF_BITS_RESET = 4'd10;

   typedef enum logic {
      CSR_COEFF_BITS = 1'b0,
      CSR_UNUSED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] coeff_0;
      logic signed [15:0] coeff_1;
      logic signed [15:0] coeff_2;
      logic signed [15:0] coeff_3;
      logic signed [15:0] coeff_4;
      logic signed [15:0] coeff_5;
      logic signed [15:0] coeff_6;
      logic signed [15:0] coeff_7;
   } req_type;

   typedef struct packed {
      logic [63:0] packed_low;
      logic [23:0] packed_high;
      logic [3:0] byte_count;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic wide;
   } ctrl_type;

endpackage

FILE: design/lccp_lane.sv
// One compression lane: conditional modulus add, scaling and rounding divide by q.
// The divide is a registered multiply by a fixed reciprocal. Depends on lccp_pkg.
module lccp_lane (
   input  logic clock,
   input  logic signed [lccp_pkg::COEFF_WIDTH-1:0] coeff,
   input  logic wide,
   output logic [lccp_pkg::QUOT_WIDTH-1:0] quot
);

   logic [lccp_pkg::COEFF_WIDTH-1:0] value;
   logic [lccp_pkg::OPERAND_WIDTH-1:0] scaled;
   logic [lccp_pkg::OPERAND_WIDTH-1:0] operand_ff;
   logic [lccp_pkg::OPERAND_WIDTH-1:0] operand_in;
   logic [lccp_pkg::PRODUCT_WIDTH-1:0] product_ff;
   logic [lccp_pkg::PRODUCT_WIDTH-1:0] product_in;

   always_comb begin
      value = coeff[lccp_pkg::COEFF_WIDTH-1] ?
              lccp_pkg::COEFF_WIDTH'(coeff + lccp_pkg::MODULUS) : coeff;
      if (wide) begin
         scaled = {1'b0, value, 11'b0};
      end else begin
         scaled = {2'b0, value, 10'b0};
      end
      operand_in = scaled + lccp_pkg::HALF_MODULUS;
      product_in = lccp_pkg::PRODUCT_WIDTH'(operand_ff) * lccp_pkg::PRODUCT_WIDTH'(lccp_pkg::RECIP);
   end

   always_ff @(posedge clock) begin
      operand_ff <= operand_in;
      product_ff <= product_in;
   end

   assign quot = product_ff[lccp_pkg::RECIP_SHIFT +: lccp_pkg::QUOT_WIDTH];

endmodule

FILE: design/lccp_merge.sv
// Merge stage: packs the eight rounded lane values bit-contiguously into the result.
// Registers the result and its strobe. Depends on lccp_pkg.
module lccp_merge (
   input  logic clock,
   input  logic reset,
   input  lccp_pkg::ctrl_type ctrl,
   input  logic [lccp_pkg::QUOT_WIDTH-1:0] quot [lccp_pkg::NUM_LANES],
   output logic rsp_valid,
   output lccp_pkg::rsp_type rsp_data
);

   logic [lccp_pkg::WIDE_PACK_BITS-1:0] wide_bits;
   logic [lccp_pkg::NARROW_PACK_BITS-1:0] narrow_bits;
   logic [lccp_pkg::WIDE_PACK_BITS-1:0] packed_bits;
   logic valid_ff;
   logic valid_in;
   lccp_pkg::rsp_type data_ff;
   lccp_pkg::rsp_type data_in;

   always_comb begin
      for (int i = 0; i < lccp_pkg::NUM_LANES; i++) begin
         wide_bits[i*11 +: 11] = quot[i];
         narrow_bits[i*10 +: 10] = quot[i][9:0];
      end
      if (ctrl.wide) begin
         packed_bits = wide_bits;
      end else begin
         packed_bits = lccp_pkg::WIDE_PACK_BITS'(narrow_bits);
      end
      data_in.packed_low = packed_bits[63:0];
      data_in.packed_high = packed_bits[87:64];
      data_in.byte_count = ctrl.wide ? lccp_pkg::WIDE_BITS : lccp_pkg::NARROW_BITS;
      valid_in = ctrl.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

FILE: design/lattice_coeff_compress_pack.sv
// Top level of the lattice coefficient compressor and packer.
// Holds the register port, eight lccp_lane instances and lccp_merge. Depends on lccp_pkg.
//
// Channel    Direction  Handshake                   Payload
// request    in         start high, busy low        req_data (lccp_pkg::req_type)
// result     out        rsp_valid strobe, 1 cycle   rsp_data (lccp_pkg::rsp_type)
// register   in/out     psel, penable, pwrite       paddr, pwdata, prdata
//
// One request is taken every cycle; busy is always low.
// Each result is registered through the lane operand register,
// the lane reciprocal product register and the packing register.
// Reset clears the pipeline strobes and sets coeff_bits to 10.
// The receiver cannot stall, so results are never held back.
module lattice_coeff_compress_pack (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  lccp_pkg::req_type req_data,
   output logic rsp_valid,
   output lccp_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [lccp_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   logic [3:0] coeff_bits_ff;
   logic [3:0] coeff_bits_in;
   logic wide;
   logic accept;
   logic csr_write;
   lccp_pkg::csr_index_type csr_index;
   lccp_pkg::ctrl_type stage1_ff;
   lccp_pkg::ctrl_type stage1_in;
   lccp_pkg::ctrl_type stage2_ff;
   logic signed [lccp_pkg::COEFF_WIDTH-1:0] coeff [lccp_pkg::NUM_LANES];
   logic [lccp_pkg::QUOT_WIDTH-1:0] quot [lccp_pkg::NUM_LANES];

   assign busy = 1'b0;
   assign pready = 1'b1;
   assign accept = start & ~busy;
   assign wide = (coeff_bits_ff == lccp_pkg::WIDE_BITS);
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = lccp_pkg::csr_index_type'(paddr[2]);

   always_comb begin
      coeff_bits_in = coeff_bits_ff;
      if (csr_write && csr_index == lccp_pkg::CSR_COEFF_BITS) begin
         coeff_bits_in = pwdata[3:0];
      end
      prdata = (csr_index == lccp_pkg::CSR_COEFF_BITS) ? {28'b0, coeff_bits_ff} : 32'b0;
      stage1_in.valid = accept;
      stage1_in.wide = wide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_bits_ff <= lccp_pkg::COEFF_BITS_RESET;
         stage1_ff <= '0;
         stage2_ff <= '0;
      end else begin
         coeff_bits_ff <= coeff_bits_in;
         stage1_ff <= stage1_in;
         stage2_ff <= stage1_ff;
      end
   end

   assign coeff[0] = req_data.coeff_0;
   assign coeff[1] = req_data.coeff_1;
   assign coeff[2] = req_data.coeff_2;
   assign coeff[3] = req_data.coeff_3;
   assign coeff[4] = req_data.coeff_4;
   assign coeff[5] = req_data.coeff_5;
   assign coeff[6] = req_data.coeff_6;
   assign coeff[7] = req_data.coeff_7;

   for (genvar i = 0; i < lccp_pkg::NUM_LANES; i++) begin : g_lane
      lccp_lane u_lane (
         .clock (clock),
         .coeff (coeff[i]),
         .wide  (wide),
         .quot  (quot[i])
      );
   end

   lccp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stage2_ff),
      .quot      (quot),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
